// ===== hdl/frl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_pkg
// Shared types, constants and the address hash of the rate limiter.
// ----------------------------------------------------------------------------
package frl_pkg;

  // Slot count; a power of two, so the hash modulo is a truncation.
  localparam int TABLE_SIZE = 1024;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int ADDR_W     = 64;
  localparam int TIME_W     = 32;
  localparam int CNT_W      = 32;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [IDX_W-1:0] HASH_SEED = IDX_W'(5381);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd2;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH_HI,
    S_HASH_LO,
    S_EVAL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] tag_hi;
    logic [ADDR_W-1:0] tag_lo;
    logic [TIME_W-1:0] start;
    logic [CNT_W-1:0]  count;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Eight djb2 steps (h*33 + byte), most significant byte first, kept modulo
  // the table size.
  function automatic logic [IDX_W-1:0] hash_word(input logic [IDX_W-1:0] h_in,
                                                  input logic [ADDR_W-1:0] word);
    logic [IDX_W-1:0] h;
    logic [7:0]       b;
    h = h_in;
    for (int i = 0; i < 8; i++) begin
      b = word[ADDR_W-1-8*i -: 8];
      h = h + (h << 5) + IDX_W'(b);
    end
    return h;
  endfunction

endpackage

// ===== hdl/frl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frl_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/fixed_window_rate_limiter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_window_rate_limiter
// Per-client fixed-window request limiter over a direct-mapped slot table.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  client_addr_high/low, now_seconds
//   out_     output     out_valid/out_stall  allowed, slot_index, window_count
//   cfg_     input      cfg_we               cfg_index, cfg_wdata
//
// A transaction runs from acceptance to result through hash of the upper
// address half, hash of the lower half with the slot table read, evaluation,
// update. The next request is accepted the cycle after the update, not before.
// After reset a clearing pass writes all 1024 slots, one per cycle, with
// input stalled. A stalled result holds the update stage until it is taken.
// ----------------------------------------------------------------------------
module fixed_window_rate_limiter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [frl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [frl_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [frl_pkg::ADDR_W-1:0]    in_client_addr_high,
  input  logic [frl_pkg::ADDR_W-1:0]    in_client_addr_low,
  input  logic [frl_pkg::TIME_W-1:0]    in_now_seconds,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_allowed,
  output logic [frl_pkg::IDX_W-1:0]     out_slot_index,
  output logic [frl_pkg::CNT_W-1:0]     out_window_count
);

  import frl_pkg::*;

  state_t state_r, state_nxt;

  logic              enable_r;
  logic [CNT_W-1:0]  limit_r;
  logic [TIME_W-1:0] window_r;

  logic [ADDR_W-1:0] addr_hi_r, addr_lo_r;
  logic [TIME_W-1:0] now_r;
  logic [IDX_W-1:0]  hash_r, hash_nxt;
  logic [IDX_W-1:0]  idx_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [CNT_W-1:0]  base_r, base_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_allowed_r;
  logic [IDX_W-1:0]  out_slot_index_r;
  logic [CNT_W-1:0]  out_window_count_r;

  logic              in_fire;
  logic              out_free;
  logic              load_out;
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  slot_entry_t       ram_wdata;
  slot_entry_t       ram_rdata;
  logic [IDX_W-1:0]  idx_lo;
  logic              hit;
  logic [TIME_W-1:0] diff;
  logic [CNT_W-1:0]  cnt_inc;

  frl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SIZE)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_lo),
    .rdata (ram_rdata)
  );

  // Configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= 1'b0;
      limit_r  <= CNT_W'(100);
      window_r <= TIME_W'(60);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        CFG_LIMIT:  if (cfg_wdata != '0) limit_r <= cfg_wdata;
        CFG_WINDOW: if (cfg_wdata != '0) window_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign idx_lo   = hash_word(hash_r, addr_lo_r);

  // Evaluation datapath
  always_comb begin
    hit  = ram_rdata.valid && (ram_rdata.tag_hi == addr_hi_r) &&
           (ram_rdata.tag_lo == addr_lo_r);
    diff = now_r - (hit ? ram_rdata.start : now_r);
    if (!hit || (diff >= window_r)) begin
      start_nxt = now_r;
      base_nxt  = '0;
    end else begin
      start_nxt = ram_rdata.start;
      base_nxt  = ram_rdata.count;
    end
    cnt_inc  = (base_r == CNT_MAX) ? CNT_MAX : base_r + CNT_W'(1);
    hash_nxt = hash_word(HASH_SEED, addr_hi_r);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:   if (clr_cnt_r == IDX_W'(TABLE_SIZE - 1)) state_nxt = S_IDLE;
      S_IDLE:    if (in_fire) state_nxt = S_HASH_HI;
      S_HASH_HI: state_nxt = S_HASH_LO;
      S_HASH_LO: state_nxt = S_EVAL;
      S_EVAL:    state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_CLEAR;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_stall  = 1'b1;
    load_out  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r;
    ram_wdata = '{valid: 1'b1, tag_hi: addr_hi_r, tag_lo: addr_lo_r,
                  start: start_r, count: cnt_inc};
    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
      end
      S_IDLE: in_stall = 1'b0;
      S_DONE: begin
        load_out = out_free;
        ram_we   = out_free && enable_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      addr_hi_r <= in_client_addr_high;
      addr_lo_r <= in_client_addr_low;
      now_r     <= in_now_seconds;
    end
    if (state_r == S_HASH_HI) begin
      hash_r <= hash_nxt;
    end
    if (state_r == S_HASH_LO) begin
      idx_r <= idx_lo;
    end
    if (state_r == S_EVAL) begin
      start_r <= start_nxt;
      base_r  <= base_nxt;
    end
    if (load_out) begin
      out_slot_index_r   <= idx_r;
      out_allowed_r      <= !enable_r || (cnt_inc <= limit_r);
      out_window_count_r <= enable_r ? cnt_inc : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_allowed      = out_allowed_r;
  assign out_slot_index   = out_slot_index_r;
  assign out_window_count = out_window_count_r;

  a_we_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR) || (state_r == S_DONE))
    else $error("slot table written outside clear or update");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result appeared without an update");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !out_valid_r && in_stall)
    else $error("activity during table clear");

  a_reject_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_allowed_r) |-> (out_window_count_r != '0))
    else $error("rejected transaction with zero count");

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks fixed_window_rate_limiter against an in-bench scoreboard model of
// the slot table. A table of directed transactions is followed by randomized
// phases, each with its own register setting. Most traffic comes from a
// small client pool with slot-colliding pairs; the clock moves forward, jumps
// or steps back. Both channels idle in random bursts, bar the last phase.
// ----------------------------------------------------------------------------
module testbench;
  import frl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [63:0]          DJB_SEED  = 64'd5381;
  localparam int                   CYCLE_LIMIT = 400000;
  localparam int                   POOL_N      = 32;
  localparam int                   PHASES      = 7;
  localparam int                   PHASE_REQS  = 150;

  localparam logic [ADDR_W-1:0] A_HI = 64'h0123_4567_89ab_cdef;
  localparam logic [ADDR_W-1:0] A_LO = 64'h0000_0000_0000_1140;
  // same djb2 hash as A_LO: byte 1 up by one, byte 0 down by 33
  localparam logic [ADDR_W-1:0] B_LO = 64'h0000_0000_0000_121f;
  localparam logic [ADDR_W-1:0] ONES = '1;
  localparam logic [TIME_W-1:0] T_MAX = '1;

  typedef struct packed {
    logic             allowed;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] count;
  } verdict_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_W-1:0]      reg_val;
    logic [ADDR_W-1:0]     hi;
    logic [ADDR_W-1:0]     lo;
    logic [TIME_W-1:0]     now;
    logic                  typed;
    logic                  allowed;
    logic [CNT_W-1:0]      count;
  } row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [ADDR_W-1:0]    in_client_addr_high = '0;
  logic [ADDR_W-1:0]    in_client_addr_low = '0;
  logic [TIME_W-1:0]    in_now_seconds = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_allowed;
  logic [IDX_W-1:0]     out_slot_index;
  logic [CNT_W-1:0]     out_window_count;

  fixed_window_rate_limiter dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scoreboard copy of the limiter
  logic              en_q;
  logic [CNT_W-1:0]  limit_q;
  logic [TIME_W-1:0] window_q;
  logic              tbl_valid [TABLE_SIZE];
  logic [ADDR_W-1:0] tbl_hi    [TABLE_SIZE];
  logic [ADDR_W-1:0] tbl_lo    [TABLE_SIZE];
  logic [TIME_W-1:0] tbl_start [TABLE_SIZE];
  logic [CNT_W-1:0]  tbl_count [TABLE_SIZE];

  verdict_t          pending [$];
  logic [ADDR_W-1:0] pool_hi [POOL_N];
  logic [ADDR_W-1:0] pool_lo [POOL_N];
  row_t              script  [33];

  bit in_idle_on  = 1'b1;
  bit out_idle_on = 1'b1;
  int errors      = 0;
  int cycles      = 0;
  int stall_left  = 0;

  function automatic logic [IDX_W-1:0] slot_of(input logic [ADDR_W-1:0] hi,
                                               input logic [ADDR_W-1:0] lo);
    logic [63:0]  h;
    logic [127:0] addr;
    h = DJB_SEED;
    addr = {hi, lo};
    for (int i = 0; i < 16; i++) h = h * 64'd33 + 64'(addr[127-8*i -: 8]);
    return h[IDX_W-1:0];
  endfunction

  function automatic verdict_t police(input logic [ADDR_W-1:0] hi,
                                      input logic [ADDR_W-1:0] lo,
                                      input logic [TIME_W-1:0] now);
    verdict_t          v;
    logic [IDX_W-1:0]  s;
    logic [TIME_W-1:0] age;
    s = slot_of(hi, lo);
    v.slot = s;
    if (!en_q) begin
      v.allowed = 1'b1;
      v.count = '0;
      return v;
    end
    if (!tbl_valid[s] || tbl_hi[s] != hi || tbl_lo[s] != lo) begin
      tbl_valid[s] = 1'b1;
      tbl_hi[s] = hi;
      tbl_lo[s] = lo;
      tbl_start[s] = now;
      tbl_count[s] = '0;
    end
    age = now - tbl_start[s];
    if (age >= window_q) begin
      tbl_start[s] = now;
      tbl_count[s] = '0;
    end
    if (tbl_count[s] != CNT_MAX) tbl_count[s] = tbl_count[s] + 1'b1;
    v.count = tbl_count[s];
    v.allowed = (v.count <= limit_q);
    return v;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_ENABLE: en_q = val[0];
      CFG_LIMIT:  if (val != '0) limit_q = val;
      CFG_WINDOW: if (val != '0) window_q = val;
      default: ;
    endcase
  endtask

  task automatic send_req(input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                          input logic [TIME_W-1:0] now, input logic typed,
                          input logic allowed, input logic [CNT_W-1:0] count);
    verdict_t v;
    cfg_we <= 1'b0;
    if (in_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_client_addr_high <= hi;
    in_client_addr_low <= lo;
    in_now_seconds <= now;
    do @(posedge clk); while (in_stall);
    v = police(hi, lo, now);
    if (typed) begin
      v.allowed = allowed;
      v.count = count;
    end
    pending.push_back(v);
  endtask

  always @(posedge clk) begin : result_check
    verdict_t exp_v;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result slot %0d", $time, out_slot_index);
      end else begin
        exp_v = pending.pop_front();
        if (out_allowed !== exp_v.allowed) begin
          errors++;
          $display("%0t: allowed exp %0d got %0d", $time, exp_v.allowed, out_allowed);
        end
        if (out_slot_index !== exp_v.slot) begin
          errors++;
          $display("%0t: slot_index exp %0d got %0d", $time, exp_v.slot, out_slot_index);
        end
        if (out_window_count !== exp_v.count) begin
          errors++;
          $display("%0t: window_count exp %0d got %0d", $time, exp_v.count,
                   out_window_count);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left == 0 && out_idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 18);
    out_stall <= (stall_left != 0);
    if (stall_left != 0) stall_left--;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL fixed_window_rate_limiter");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0]  lim_v;
    logic [CFG_W-1:0]  win_v;
    logic [CFG_W-1:0]  en_v;
    logic [TIME_W-1:0] clock_t;
    logic [TIME_W-1:0] now_v;
    logic [ADDR_W-1:0] hi_v;
    logic [ADDR_W-1:0] lo_v;
    int                r;
    int                k;

    en_q = 1'b0;
    limit_q = 32'd100;
    window_q = 32'd60;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;

    for (int i = 0; i < POOL_N; i += 2) begin
      pool_hi[i] = {$urandom, $urandom};
      pool_lo[i] = {$urandom, 16'($urandom), 8'($urandom_range(0, 254)),
                    8'($urandom_range(33, 255))};
      pool_hi[i+1] = pool_hi[i];
      pool_lo[i+1] = pool_lo[i] + 64'd223;
    end

    script = '{
      '{ROW_ITEM, CFG_ENABLE, 0, 0, 0, 0, 1'b1, 1'b1, 0},
      '{ROW_ITEM, CFG_ENABLE, 0, ONES, ONES, T_MAX, 1'b1, 1'b1, 0},
      '{ROW_CFG, CFG_ENABLE, 32'd1, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_CFG, CFG_LIMIT, 32'd2, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_CFG, CFG_WINDOW, 32'd10, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_CFG, CFG_LIMIT, 32'd0, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_CFG, CFG_WINDOW, 32'd0, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_CFG, CFG_SPARE, 32'h5a5a_a5a5, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd100, 1'b1, 1'b1, 32'd1},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd101, 1'b1, 1'b1, 32'd2},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd105, 1'b1, 1'b0, 32'd3},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd109, 1'b1, 1'b0, 32'd4},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd110, 1'b1, 1'b1, 32'd1},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd50, 1'b1, 1'b1, 32'd1},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, B_LO, 32'd51, 1'b1, 1'b1, 32'd1},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd52, 1'b1, 1'b1, 32'd1},
      '{ROW_ITEM, CFG_ENABLE, 0, ONES, ONES, T_MAX, 1'b1, 1'b1, 32'd1},
      '{ROW_ITEM, CFG_ENABLE, 0, ONES, ONES, 32'd0, 1'b1, 1'b1, 32'd2},
      '{ROW_ITEM, CFG_ENABLE, 0, ONES, ONES, 32'd5, 1'b1, 1'b0, 32'd3},
      '{ROW_CFG, CFG_LIMIT, 32'hffff_ffff, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_CFG, CFG_WINDOW, 32'hffff_ffff, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_ITEM, CFG_ENABLE, 0, ONES, ONES, 32'd6, 1'b1, 1'b1, 32'd4},
      '{ROW_ITEM, CFG_ENABLE, 0, ONES, ONES, 32'hffff_fffe, 1'b1, 1'b1, 32'd1},
      '{ROW_CFG, CFG_LIMIT, 32'd1, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_CFG, CFG_WINDOW, 32'd1, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd60, 1'b1, 1'b1, 32'd1},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd60, 1'b1, 1'b0, 32'd2},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd61, 1'b1, 1'b1, 32'd1},
      '{ROW_CFG, CFG_ENABLE, 32'd0, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd61, 1'b1, 1'b1, 32'd0},
      '{ROW_CFG, CFG_ENABLE, 32'd1, 0, 0, 0, 1'b0, 1'b0, 0},
      '{ROW_ITEM, CFG_ENABLE, 0, A_HI, A_LO, 32'd61, 1'b1, 1'b0, 32'd2},
      '{ROW_ITEM, CFG_ENABLE, 0, 0, 0, 0, 1'b0, 1'b0, 0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].kind == ROW_CFG)
        write_reg(script[i].reg_idx, script[i].reg_val);
      else
        send_req(script[i].hi, script[i].lo, script[i].now, script[i].typed,
                 script[i].allowed, script[i].count);
    end

    for (int p = 0; p < PHASES; p++) begin
      in_idle_on = (p != PHASES - 1);
      out_idle_on = (p != PHASES - 1);
      en_v = $urandom;
      en_v[0] = (p != 3);
      case ($urandom_range(0, 5))
        0: lim_v = 32'd1;
        1: lim_v = 32'hffff_ffff;
        2: lim_v = 32'd0;
        default: lim_v = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 5))
        0: win_v = 32'd1;
        1: win_v = 32'hffff_ffff;
        2: win_v = 32'd0;
        3: win_v = $urandom;
        default: win_v = $urandom_range(2, 20);
      endcase
      write_reg(CFG_ENABLE, en_v);
      write_reg(CFG_LIMIT, lim_v);
      write_reg(CFG_WINDOW, win_v);
      if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, $urandom);
      clock_t = $urandom;
      repeat (PHASE_REQS) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          k = $urandom_range(0, POOL_N - 1);
          hi_v = pool_hi[k];
          lo_v = pool_lo[k];
        end else begin
          hi_v = {$urandom, $urandom};
          lo_v = {$urandom, $urandom};
        end
        r = $urandom_range(0, 99);
        if (r < 70) clock_t = clock_t + $urandom_range(0, 3);
        else if (r < 82) clock_t = clock_t + $urandom_range(4, 40);
        else if (r < 90) clock_t = clock_t - $urandom_range(1, 50);
        else if (r < 95) clock_t = $urandom;
        now_v = (r >= 95) ? TIME_W'($urandom) : clock_t;
        send_req(hi_v, lo_v, now_v, 1'b0, 1'b0, '0);
      end
    end

    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0)
      $display("PASS fixed_window_rate_limiter");
    else
      $display("FAIL fixed_window_rate_limiter");
    $finish;
  end

endmodule
